### rtl/core/lag_one_phase_frequency_estimator_top_assert.svh
// ----------------------------------------------------------------------------
// Lag-one phase frequency estimator assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef LAG_ONE_PHASE_FREQUENCY_ESTIMATOR_TOP_ASSERT_SVH
`define LAG_ONE_PHASE_FREQUENCY_ESTIMATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LOFE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lofe assertion failed");
// next-cycle implication
`define LOFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lofe assertion failed");
`else
`define LOFE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LOFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/lofe_pkg.sv
// ----------------------------------------------------------------------------
// Lag-one phase frequency estimator package
// Shared constants, the arctangent table and controller/datapath types.
// ----------------------------------------------------------------------------
package lofe_pkg;

    // parameter defaults
    localparam int DEF_MAX_STEP      = 1024;
    localparam int DEF_WINDOW_BLOCKS = 3;
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_ANGLE_BITS    = 16;
    localparam int DEF_CORDIC_STEPS  = 16;

    // configuration registers
    localparam int STEP_REG_W  = 11;
    localparam int COUNT_REG_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 2'd1;
    localparam logic [STEP_REG_W-1:0]  STEP_RESET  = 11'd16;
    localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 13'd256;
    localparam logic [COUNT_REG_W-1:0] COUNT_LIMIT = 13'd4096;

    localparam int BLOCK_IDX_W = 12;

    // angle unit: normalized magnitude lies in [2^NORM_EXP, 2^(NORM_EXP+1))
    localparam int NORM_EXP = 40;
    localparam int XY_W     = 44;
    localparam int Z_W      = 34;
    localparam int ATAN_W   = 32;
    localparam int ZPI_BITS = 32;
    localparam logic signed [Z_W-1:0] Z_PI = 34'sh0_8000_0000;

    // atan(2^-i), 2^31 = pi
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DECIDE,
        ST_SUM,
        ST_PREP,
        ST_NORM,
        ST_ITER,
        ST_FIN,
        ST_EMIT,
        ST_BURST,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic sum;
        logic prep;
        logic norm;
        logic iter;
        logic fin;
        logic emit;
        logic emit_last;
        logic emit_err;
        logic clear_ray;
    } dp_cmd_t;

    typedef struct packed {
        logic ray_done;
        logic win;
        logic final_blk;
        logic ray_end;
        logic zero_sum;
        logic norm_done;
        logic iter_last;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/lofe_ctrl.sv
// ----------------------------------------------------------------------------
// Lag-one phase frequency estimator controller
// Sequences one sample through multiply, accumulate, angle and emit steps.
// ----------------------------------------------------------------------------
module lofe_ctrl #(
    parameter int WINDOW_BLOCKS = lofe_pkg::DEF_WINDOW_BLOCKS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lofe_pkg::dp_status_t st,
    output lofe_pkg::dp_cmd_t    cmd
);

    localparam int BURST_W = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
    localparam logic [BURST_W-1:0] BURST_LAST = BURST_W'(WINDOW_BLOCKS - 1);

    lofe_pkg::state_t   state_reg, state_next;
    logic [BURST_W-1:0] burst_reg, burst_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lofe_pkg::ST_IDLE;
            burst_reg <= '0;
        end else begin
            state_reg <= state_next;
            burst_reg <= burst_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        burst_next = burst_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            lofe_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    // a finished ray absorbs samples inside the datapath
                    if (!st.ray_done) begin
                        state_next = lofe_pkg::ST_MUL;
                    end
                end
            end
            lofe_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = lofe_pkg::ST_ACC;
            end
            lofe_pkg::ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = lofe_pkg::ST_DECIDE;
            end
            lofe_pkg::ST_DECIDE: begin
                priority if (st.win) begin
                    state_next = lofe_pkg::ST_SUM;
                end else if (st.ray_end) begin
                    state_next = lofe_pkg::ST_ERR;
                end else begin
                    state_next = lofe_pkg::ST_IDLE;
                end
            end
            lofe_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = lofe_pkg::ST_PREP;
            end
            lofe_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = st.zero_sum ? lofe_pkg::ST_EMIT : lofe_pkg::ST_NORM;
            end
            lofe_pkg::ST_NORM: begin
                cmd.norm = 1'b1;
                if (st.norm_done) begin
                    state_next = lofe_pkg::ST_ITER;
                end
            end
            lofe_pkg::ST_ITER: begin
                cmd.iter = 1'b1;
                if (st.iter_last) begin
                    state_next = lofe_pkg::ST_FIN;
                end
            end
            lofe_pkg::ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = lofe_pkg::ST_EMIT;
            end
            lofe_pkg::ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    priority if (st.final_blk) begin
                        burst_next = '0;
                        state_next = lofe_pkg::ST_BURST;
                    end else if (st.ray_end) begin
                        state_next = lofe_pkg::ST_ERR;
                    end else begin
                        state_next = lofe_pkg::ST_IDLE;
                    end
                end
            end
            lofe_pkg::ST_BURST: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    if (burst_reg == BURST_LAST) begin
                        cmd.emit_last  = 1'b1;
                        cmd.clear_ray  = st.ray_end;
                        state_next     = lofe_pkg::ST_IDLE;
                    end else begin
                        burst_next = burst_reg + 1'b1;
                    end
                end
            end
            lofe_pkg::ST_ERR: begin
                if (st.out_free) begin
                    cmd.emit_err  = 1'b1;
                    cmd.clear_ray = 1'b1;
                    state_next    = lofe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lofe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/lofe_dpath.sv
// ----------------------------------------------------------------------------
// Lag-one phase frequency estimator datapath
// Config registers, lag-one products, block ring, CORDIC angle unit, output.
// ----------------------------------------------------------------------------
module lofe_dpath #(
    parameter int MAX_STEP      = lofe_pkg::DEF_MAX_STEP,
    parameter int WINDOW_BLOCKS = lofe_pkg::DEF_WINDOW_BLOCKS,
    parameter int SAMPLE_BITS   = lofe_pkg::DEF_SAMPLE_BITS,
    parameter int ANGLE_BITS    = lofe_pkg::DEF_ANGLE_BITS,
    parameter int CORDIC_STEPS  = lofe_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lofe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lofe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]         sample_re,
    input  logic signed [SAMPLE_BITS-1:0]         sample_im,
    input  logic                                  ray_end,
    input  lofe_pkg::dp_cmd_t                     cmd,
    output lofe_pkg::dp_status_t                  st,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ANGLE_BITS-1:0]                 out_angle,
    output logic                                  out_status,
    output logic                                  out_last
);

    localparam int CNT_W      = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int STEP_EFF_W = $clog2(MAX_STEP + 1);
    localparam int PROD_W     = 2 * SAMPLE_BITS + 1;
    localparam int SUM_W      = PROD_W + CNT_W;
    localparam int WIN_W      = SUM_W + $clog2(WINDOW_BLOCKS + 1);
    localparam int MAG_W      = (WIN_W > lofe_pkg::NORM_EXP + 2) ? WIN_W
                                                                 : lofe_pkg::NORM_EXP + 2;
    localparam int SLOT_W     = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
    localparam int ITER_W     = $clog2(CORDIC_STEPS);
    localparam int ANGLE_SH   = lofe_pkg::ZPI_BITS - ANGLE_BITS;
    localparam int BIW        = lofe_pkg::BLOCK_IDX_W;
    localparam int CW         = lofe_pkg::COUNT_REG_W;
    localparam int XYW        = lofe_pkg::XY_W;
    localparam int ZW         = lofe_pkg::Z_W;
    localparam logic signed [ZW-1:0] Z_RND = ZW'(1) << (ANGLE_SH - 1);

    // configuration
    logic [lofe_pkg::STEP_REG_W-1:0] step_cfg_reg;
    logic [CW-1:0]                   count_cfg_reg;
    logic [31:0]                     step_wide;
    logic [STEP_EFF_W-1:0]           step_eff;
    logic [CW-1:0]                   count_eff;

    // sample and ray state
    logic signed [SAMPLE_BITS-1:0] smp_re_reg, smp_im_reg, prev_re_reg, prev_im_reg;
    logic                          end_reg, have_prev_reg, ray_done_reg;
    logic                          win_reg, final_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_a_reg, prod_b_reg, prod_c_reg, prod_d_reg;
    logic signed [SUM_W-1:0]       sum_re_reg [WINDOW_BLOCKS];
    logic signed [SUM_W-1:0]       sum_im_reg [WINDOW_BLOCKS];
    logic [SLOT_W-1:0]             slot_reg;
    logic [CNT_W-1:0]              sib_reg;
    logic [BIW-1:0]                bidx_reg;

    // angle unit
    logic signed [WIN_W-1:0] win_re_reg, win_im_reg;
    logic [MAG_W-1:0]        mx_reg, my_reg;
    logic                    negy_reg;
    logic signed [XYW-1:0]   x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [ANGLE_BITS-1:0]   angle_reg;

    // output register
    logic                  out_valid_reg;
    logic [ANGLE_BITS-1:0] out_angle_reg;
    logic                  out_status_reg, out_last_reg;

    // combinational helpers
    logic signed [PROD_W-1:0] term_re, term_im;
    logic signed [SUM_W-1:0]  base_re, base_im;
    logic [CNT_W:0]           sib_inc;
    logic                     close_now, win_now, final_now, do_clear;
    logic signed [WIN_W-1:0]  acc_re, acc_im;
    logic                     nx, ny;
    logic [WIN_W-1:0]         ux, uy;
    logic [MAG_W-1:0]         mag_or;
    logic                     mag_hi, mag_lo;
    logic signed [XYW-1:0]    dx, dy;
    logic [lofe_pkg::ATAN_W-1:0] atan_v;
    logic signed [ZW-1:0]     z_rnd;

    // clamp the registers into their legal ranges
    always_comb begin
        step_wide = 32'(step_cfg_reg);
        if (step_wide == 32'd0) begin
            step_wide = 32'd1;
        end else if (step_wide > 32'(MAX_STEP)) begin
            step_wide = 32'(MAX_STEP);
        end
        step_eff = STEP_EFF_W'(step_wide);
        if (count_cfg_reg < CW'(WINDOW_BLOCKS + 1)) begin
            count_eff = CW'(WINDOW_BLOCKS + 1);
        end else if (count_cfg_reg > lofe_pkg::COUNT_LIMIT) begin
            count_eff = lofe_pkg::COUNT_LIMIT;
        end else begin
            count_eff = count_cfg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cfg_reg  <= lofe_pkg::STEP_RESET;
            count_cfg_reg <= lofe_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lofe_pkg::CFG_IDX_STEP:  step_cfg_reg  <= cfg_wdata[lofe_pkg::STEP_REG_W-1:0];
                lofe_pkg::CFG_IDX_COUNT: count_cfg_reg <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // block bookkeeping for the accumulate step
    always_comb begin
        term_re   = PROD_W'(prod_a_reg) + PROD_W'(prod_b_reg);
        term_im   = PROD_W'(prod_c_reg) - PROD_W'(prod_d_reg);
        base_re   = (sib_reg == '0) ? '0 : sum_re_reg[slot_reg];
        base_im   = (sib_reg == '0) ? '0 : sum_im_reg[slot_reg];
        sib_inc   = {1'b0, sib_reg} + 1'b1;
        close_now = sib_inc >= (CNT_W + 1)'(step_eff);
        win_now   = close_now && (bidx_reg >= BIW'(WINDOW_BLOCKS - 1));
        final_now = win_now && ({1'b0, bidx_reg} >= (count_eff - CW'(2)));
        do_clear  = cmd.clear_ray || (cmd.load && ray_done_reg && ray_end);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            smp_re_reg <= sample_re;
            smp_im_reg <= sample_im;
            end_reg    <= ray_end;
        end
        if (cmd.mul) begin
            prod_a_reg <= smp_re_reg * prev_re_reg;
            prod_b_reg <= smp_im_reg * prev_im_reg;
            prod_c_reg <= smp_im_reg * prev_re_reg;
            prod_d_reg <= smp_re_reg * prev_im_reg;
        end
        if (cmd.acc) begin
            sum_re_reg[slot_reg] <= base_re + (have_prev_reg ? SUM_W'(term_re) : '0);
            sum_im_reg[slot_reg] <= base_im + (have_prev_reg ? SUM_W'(term_im) : '0);
            prev_re_reg          <= smp_re_reg;
            prev_im_reg          <= smp_im_reg;
            win_reg              <= win_now;
            final_reg            <= final_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            ray_done_reg  <= 1'b0;
            sib_reg       <= '0;
            bidx_reg      <= '0;
            slot_reg      <= '0;
        end else if (do_clear) begin
            have_prev_reg <= 1'b0;
            ray_done_reg  <= 1'b0;
            sib_reg       <= '0;
            bidx_reg      <= '0;
            slot_reg      <= '0;
        end else if (cmd.acc) begin
            have_prev_reg <= 1'b1;
            if (close_now) begin
                sib_reg <= '0;
                if (final_now) begin
                    ray_done_reg <= 1'b1;
                end else begin
                    bidx_reg <= bidx_reg + 1'b1;
                    slot_reg <= (slot_reg == SLOT_W'(WINDOW_BLOCKS - 1)) ? '0
                                                                        : slot_reg + 1'b1;
                end
            end else begin
                sib_reg <= sib_inc[CNT_W-1:0];
            end
        end
    end

    // window sum over the block ring
    always_comb begin
        acc_re = '0;
        acc_im = '0;
        for (int b = 0; b < WINDOW_BLOCKS; b++) begin
            acc_re = acc_re + WIN_W'(sum_re_reg[b]);
            acc_im = acc_im + WIN_W'(sum_im_reg[b]);
        end
    end

    // angle unit helpers
    always_comb begin
        nx     = win_re_reg[WIN_W-1];
        ny     = win_im_reg[WIN_W-1];
        ux     = nx ? WIN_W'(-win_re_reg) : WIN_W'(win_re_reg);
        uy     = ny ? WIN_W'(-win_im_reg) : WIN_W'(win_im_reg);
        mag_or = mx_reg | my_reg;
        mag_hi = |mag_or[MAG_W-1:lofe_pkg::NORM_EXP+1];
        mag_lo = !mag_hi && !mag_or[lofe_pkg::NORM_EXP];
        dx     = y_reg >>> iter_reg;
        dy     = x_reg >>> iter_reg;
        atan_v = lofe_pkg::atan_entry(5'(iter_reg));
        z_rnd  = Z_RND - z_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            win_re_reg <= acc_re;
            win_im_reg <= acc_im;
        end
        if (cmd.prep) begin
            // rotate left half-plane vectors by pi before vectoring
            mx_reg   <= MAG_W'(ux);
            my_reg   <= MAG_W'(uy);
            negy_reg <= ny ^ nx;
            z_reg    <= nx ? (ny ? -lofe_pkg::Z_PI : lofe_pkg::Z_PI) : '0;
            if (ux == '0 && uy == '0) begin
                angle_reg <= '0;
            end
        end
        if (cmd.norm) begin
            priority if (mag_hi) begin
                mx_reg <= mx_reg >> 1;
                my_reg <= my_reg >> 1;
            end else if (mag_lo) begin
                mx_reg <= mx_reg << 1;
                my_reg <= my_reg << 1;
            end else begin
                x_reg    <= XYW'(mx_reg);
                y_reg    <= negy_reg ? -XYW'(my_reg) : XYW'(my_reg);
                iter_reg <= '0;
            end
        end
        if (cmd.iter) begin
            if (!y_reg[XYW-1] && (y_reg != '0)) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ZW'(atan_v);
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ZW'(atan_v);
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.fin) begin
            // negate, round half up, wrap
            angle_reg <= z_rnd[ANGLE_SH+ANGLE_BITS-1:ANGLE_SH];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_err) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_err) begin
            out_angle_reg  <= '0;
            out_status_reg <= 1'b1;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit) begin
            out_angle_reg  <= angle_reg;
            out_status_reg <= 1'b0;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_angle  = out_angle_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    always_comb begin
        st.ray_done  = ray_done_reg;
        st.win       = win_reg;
        st.final_blk = final_reg;
        st.ray_end   = end_reg;
        st.zero_sum  = (win_re_reg == '0) && (win_im_reg == '0);
        st.norm_done = !mag_hi && !mag_lo;
        st.iter_last = iter_reg == ITER_W'(CORDIC_STEPS - 1);
        st.out_free  = !out_valid_reg || out_ready;
    end

endmodule

### rtl/core/lag_one_phase_frequency_estimator_top.sv
// ----------------------------------------------------------------------------
// Lag-one phase frequency estimator, top level
// Kasai lag-one autocorrelation per block, windowed, angle by CORDIC.
// ----------------------------------------------------------------------------
// An ordinary sample passes accept, multiply, accumulate and decide; the next is
// taken only once idle again. A block-closing sample with a window runs sum,
// prepare, normalize (one bit per cycle), CORDIC steps and finish (the last three
// skip on a zero sum) and emits a result, 4 on last block, +1 on early ray end.
// Reset (aresetn low, synchronous): clear ray state and handshakes, set
// block_step to 16 and output_count to 256; no clearing pass is needed.
module lag_one_phase_frequency_estimator_top #(
    parameter int MAX_STEP      = lofe_pkg::DEF_MAX_STEP,
    parameter int WINDOW_BLOCKS = lofe_pkg::DEF_WINDOW_BLOCKS,
    parameter int SAMPLE_BITS   = lofe_pkg::DEF_SAMPLE_BITS,
    parameter int ANGLE_BITS    = lofe_pkg::DEF_ANGLE_BITS,
    parameter int CORDIC_STEPS  = lofe_pkg::DEF_CORDIC_STEPS,
    localparam int S_TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((ANGLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [lofe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lofe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // sample items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,   // sample_re, sample_im, zero pad
    input  logic                            s_tlast,   // ray_end
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_TDATA_W-1:0]            m_tdata,   // phase_angle, zero pad
    output logic                            m_tuser,   // status
    output logic                            m_tlast    // last_of_ray
);

`include "lag_one_phase_frequency_estimator_top_assert.svh"

    lofe_pkg::dp_cmd_t     cmd;
    lofe_pkg::dp_status_t  st;
    logic [ANGLE_BITS-1:0] out_angle;

    // controller: one sample at a time through the datapath
    lofe_ctrl #(
        .WINDOW_BLOCKS (WINDOW_BLOCKS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: products, block ring, angle unit and output register
    lofe_dpath #(
        .MAX_STEP      (MAX_STEP),
        .WINDOW_BLOCKS (WINDOW_BLOCKS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample_re  (s_tdata[SAMPLE_BITS-1:0]),
        .sample_im  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .ray_end    (s_tlast),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_angle  (out_angle),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    // zero-pad the angle to whole bytes
    assign m_tdata = M_TDATA_W'(out_angle);

    // an error result always closes the ray
    `LOFE_ASSERT_IMPL(a_err_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    // never load the output register while it still holds an untaken item
    `LOFE_ASSERT_IMPL(a_emit_when_free, aclk, aresetn, cmd.emit || cmd.emit_err, st.out_free)
    // a sample of a live ray keeps intake closed while it is worked on
    `LOFE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
                      s_tvalid && s_tready && !st.ray_done, !s_tready)

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Lag-one phase frequency estimator testbench
// Streams rays of complex samples into the estimator under several block and
// count settings, predicts every angle, error and end-of-ray result, and
// checks the result stream item by item while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lofe_pkg::*;

    localparam int WINDOW       = DEF_WINDOW_BLOCKS;
    localparam int STEP_MAX     = DEF_MAX_STEP;
    localparam int COUNT_MAX    = int'(COUNT_LIMIT);
    localparam int ANGLE_ITERS  = DEF_CORDIC_STEPS;
    localparam longint PI_Q31   = 64'sd2147483648;
    localparam int DRAIN_GUARD  = 120;      // covers the worst block latency
    localparam int CYCLE_LIMIT  = 1000000;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef struct {
        logic [15:0] angle;
        logic        status;
        logic        last_of_ray;
    } angle_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the ray state and the registers,
    // predicts the results of each accepted sample and checks them in order.
    // ------------------------------------------------------------------------
    class angle_scoreboard;
        logic [STEP_REG_W-1:0]  step_reg;
        logic [COUNT_REG_W-1:0] count_reg;
        longint        prev_re;
        longint        prev_im;
        bit            have_prev;
        longint        blk_re [WINDOW];
        longint        blk_im [WINDOW];
        int            pos_in_blk;
        int            blk_idx;
        logic [15:0]   held_angle;
        bit            ray_closed;
        angle_result_t expected_angles [$];
        int            mismatches;

        function new();
            step_reg   = STEP_RESET;
            count_reg  = COUNT_RESET;
            mismatches = 0;
            clear_ray();
        endfunction

        function void clear_ray();
            prev_re    = 0;
            prev_im    = 0;
            have_prev  = 0;
            for (int b = 0; b < WINDOW; b++) begin
                blk_re[b] = 0;
                blk_im[b] = 0;
            end
            pos_in_blk = 0;
            blk_idx    = 0;
            held_angle = '0;
            ray_closed = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_IDX_STEP) begin
                step_reg = value[STEP_REG_W-1:0];
            end else if (idx == CFG_IDX_COUNT) begin
                count_reg = value[COUNT_REG_W-1:0];
            end
        endfunction

        function longint arctan_q31(input int k);
            case (k)
                0:  return 536870912;
                1:  return 316933406;
                2:  return 167458907;
                3:  return 85004756;
                4:  return 42667331;
                5:  return 21354465;
                6:  return 10680862;
                7:  return 5340245;
                8:  return 2670163;
                9:  return 1335087;
                10: return 667544;
                11: return 333772;
                12: return 166886;
                13: return 83443;
                14: return 41722;
                15: return 20861;
                default: return 0;
            endcase
        endfunction

        // negated argument of the window sum, pi = 2^15 after rounding
        function logic [15:0] neg_window_angle(input longint sum_re, input longint sum_im);
            longint unsigned mag_x;
            longint unsigned mag_y;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            bit     neg_x;
            bit     neg_y;
            neg_x = sum_re < 0;
            neg_y = sum_im < 0;
            mag_x = neg_x ? -sum_re : sum_re;
            mag_y = neg_y ? -sum_im : sum_im;
            if (mag_x == 0 && mag_y == 0) begin
                return '0;
            end
            z = 0;
            // turn the left half plane by pi before vectoring
            if (neg_x) begin
                z = neg_y ? -PI_Q31 : PI_Q31;
                neg_y = !neg_y;
            end
            while ((mag_x | mag_y) >= (64'd1 << 41)) begin
                mag_x = mag_x >> 1;
                mag_y = mag_y >> 1;
            end
            while ((mag_x | mag_y) < (64'd1 << 40)) begin
                mag_x = mag_x << 1;
                mag_y = mag_y << 1;
            end
            x = longint'(mag_x);
            y = neg_y ? -longint'(mag_y) : longint'(mag_y);
            for (int k = 0; k < ANGLE_ITERS; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_q31(k);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_q31(k);
                end
            end
            z = (longint'(32768) - z) >>> 16;
            return z[15:0];
        endfunction

        function void queue_result(input logic [15:0] angle, input logic status,
                                   input logic last_of_ray);
            angle_result_t r;
            r.angle       = angle;
            r.status      = status;
            r.last_of_ray = last_of_ray;
            expected_angles.push_back(r);
        endfunction

        // predict the results of one accepted sample
        function void absorb_sample(input logic signed [15:0] s_re,
                                    input logic signed [15:0] s_im,
                                    input logic ray_end);
            int     step;
            int     count;
            int     slot;
            longint re;
            longint im;
            longint sum_re;
            longint sum_im;
            step  = int'(step_reg);
            count = int'(count_reg);
            re    = s_re;
            im    = s_im;
            if (step < 1) step = 1;
            if (step > STEP_MAX) step = STEP_MAX;
            if (count < WINDOW + 1) count = WINDOW + 1;
            if (count > COUNT_MAX) count = COUNT_MAX;

            // finished ray: drop samples until the ray end
            if (ray_closed) begin
                if (ray_end) clear_ray();
                return;
            end
            slot = blk_idx % WINDOW;
            if (pos_in_blk == 0) begin
                blk_re[slot] = 0;
                blk_im[slot] = 0;
            end
            if (have_prev) begin
                blk_re[slot] += re * prev_re + im * prev_im;
                blk_im[slot] += im * prev_re - re * prev_im;
            end
            prev_re   = re;
            prev_im   = im;
            have_prev = 1;

            if (pos_in_blk + 1 >= step) begin
                pos_in_blk = 0;
                if (blk_idx >= WINDOW - 1) begin
                    sum_re = 0;
                    sum_im = 0;
                    for (int b = 0; b < WINDOW; b++) begin
                        sum_re += blk_re[b];
                        sum_im += blk_im[b];
                    end
                    held_angle = neg_window_angle(sum_re, sum_im);
                    queue_result(held_angle, 1'b0, 1'b0);
                    // final block: repeat the angle and mark the last one
                    if (blk_idx >= count - 2) begin
                        for (int b = 0; b < WINDOW; b++) begin
                            queue_result(held_angle, 1'b0, b == WINDOW - 1);
                        end
                        ray_closed = 1;
                    end
                end
                if (!ray_closed) blk_idx = (blk_idx + 1) & 'hFFF;
            end else begin
                pos_in_blk++;
            end

            if (ray_end) begin
                if (!ray_closed) queue_result('0, 1'b1, 1'b1);
                clear_ray();
            end
        endfunction

        function void check_angle(input logic [15:0] angle, input logic status,
                                  input logic last_of_ray);
            angle_result_t want;
            if (expected_angles.size() == 0) begin
                $error("unexpected result: phase_angle %0d status %0d last_of_ray %0d",
                       $signed(angle), status, last_of_ray);
                mismatches++;
                return;
            end
            want = expected_angles.pop_front();
            if (angle !== want.angle) begin
                $error("phase_angle mismatch: expected %0d, actual %0d",
                       $signed(want.angle), $signed(angle));
                mismatches++;
            end
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (last_of_ray !== want.last_of_ray) begin
                $error("last_of_ray mismatch: expected %0d, actual %0d",
                       want.last_of_ray, last_of_ray);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;     // sample_re, sample_im
    logic                   s_tlast = 1'b0;   // ray_end
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;          // phase_angle
    logic                   m_tuser;          // status
    logic                   m_tlast;          // last_of_ray

    angle_scoreboard sb;
    int src_idle_pct = 0;   // chance per cycle that the sender idles
    int snk_idle_pct = 0;   // chance per cycle that the receiver stalls
    int sink_hold    = 0;   // cycles left of a forced receiver hold-off
    int cur_step     = 1;   // effective register values for ray shaping
    int cur_count    = 4;
    int fed          = 0;   // samples sent that belong to live rays

    lag_one_phase_frequency_estimator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: decide ready on the falling edge; a forced hold-off wins over
    // the random stalls and counts down in this process.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Check every result item accepted at a rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_angle(m_tdata, m_tuser, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers; every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Write one register, then drop the enable again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic set_shape(input int step, input int count);
        write_reg(CFG_IDX_STEP, step[CFG_DATA_W-1:0]);
        write_reg(CFG_IDX_COUNT, count[CFG_DATA_W-1:0]);
        cur_step  = step;
        cur_count = count;
    endtask

    // Offer one sample, idling at random first; hold it until accepted.
    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic ray_end);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        s_tlast  <= ray_end;
        do @(posedge aclk); while (!s_tready);
        sb.absorb_sample(re, im, ray_end);
        @(negedge aclk);
    endtask

    // Pause the sender until every expected result is in, then let the
    // block settle so a register write finds it idle.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        repeat (DRAIN_GUARD) @(negedge aclk);
    endtask

    function automatic logic signed [15:0] pick_component();
        int                 sel;
        logic signed [15:0] v;
        sel = $urandom_range(99);
        if (sel < 55) begin
            v = 16'($urandom);
        end else if (sel < 82) begin
            v = 16'($urandom_range(0, 511));
            v = v - 16'sd256;
        end else begin
            case ($urandom_range(3))
                0:       v = 16'sh8000;
                1:       v = 16'sh7FFF;
                2:       v = 16'sh0000;
                default: v = 16'shFFFF;
            endcase
        end
        return v;
    endfunction

    // Whole ray under the current shape, ray end on the completing sample.
    task automatic send_complete_ray();
        int full;
        full = cur_step * (cur_count - 1);
        for (int i = 0; i < full; i++) begin
            send_sample(pick_component(), pick_component(), i == full - 1);
        end
        fed += full;
    endtask

    // Mostly well-formed rays, some trailing samples that the block drops;
    // the rest end early at a random point.
    task automatic run_ray();
        int full;
        int cut;
        int extra;
        full = cur_step * (cur_count - 1);
        if ($urandom_range(99) < 70) begin
            extra = $urandom_range(0, 3);
            for (int i = 0; i < full; i++) begin
                send_sample(pick_component(), pick_component(), extra == 0 && i == full - 1);
            end
            for (int j = 1; j <= extra; j++) begin
                send_sample(pick_component(), pick_component(), j == extra);
            end
            fed += full;
        end else begin
            cut = $urandom_range(1, full - 1);
            for (int i = 0; i < cut; i++) begin
                send_sample(pick_component(), pick_component(), i == cut - 1);
            end
            fed += cut;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles now and then, receiver mostly stalls
        src_idle_pct = 17;
        snk_idle_pct = 79;

        // below-range values clamp to a step of 1 and a count of 4;
        // the spare indexes must leave both registers alone
        write_reg(CFG_IDX_STEP, 13'd0);
        write_reg(CFG_IDX_COUNT, 13'd2);
        write_reg(CFG_IDX_SPARE_A, 13'h1FFF);
        write_reg(CFG_IDX_SPARE_B, 13'h0155);
        cur_step  = 1;
        cur_count = 4;

        // full-scale samples; trailing samples are dropped until the ray end
        send_sample(16'sh7FFF, 16'sh8000, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(16'shFFFF, 16'shFFFF, 1'b1);
        // zero window sum, ray end on the completing sample
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        // negative real sum with zero imaginary part: angle of plus pi
        send_sample(16'sd1000, 16'sd0, 1'b0);
        send_sample(-16'sd1000, 16'sd0, 1'b0);
        send_sample(16'sd1000, 16'sd0, 1'b1);
        // negative real and imaginary sum
        send_sample(16'sd1000, 16'sd0, 1'b0);
        send_sample(-16'sd1000, -16'sd5, 1'b0);
        send_sample(16'sd900, 16'sd10, 1'b1);
        // early ray ends, one on the very first sample
        send_sample(16'sd100, 16'sd200, 1'b0);
        send_sample(16'sd300, -16'sd400, 1'b1);
        send_sample(16'sd5, -16'sd5, 1'b1);
        fed = 17;
        wait_results_drained();

        // random rays, small shapes
        set_shape($urandom_range(1, 4), $urandom_range(4, 9));
        while (fed < 90) run_ray();
        // leave a ray open across a step change
        send_sample(pick_component(), pick_component(), 1'b0);
        send_sample(pick_component(), pick_component(), 1'b0);
        fed += 2;
        wait_results_drained();

        // swap the idle pattern: sender sparse, receiver mostly ready
        src_idle_pct = 79;
        snk_idle_pct = 17;
        set_shape($urandom_range(1, 5), $urandom_range(4, 8));
        while (fed < 165) run_ray();
        wait_results_drained();

        // no idling; hold the receiver off long enough to back up the input
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_shape(1, 12);
        sink_hold = 300;
        send_complete_ray();
        send_complete_ray();
        wait_results_drained();
        set_shape($urandom_range(1, 3), $urandom_range(4, 10));
        while (fed < 240) run_ray();
        wait_results_drained();

        // largest step with the smallest count: one whole ray
        set_shape(STEP_MAX, WINDOW + 1);
        send_complete_ray();
        wait_results_drained();

        // above-range values clamp to the largest step and count
        write_reg(CFG_IDX_STEP, 13'd2047);
        write_reg(CFG_IDX_COUNT, 13'd8191);
        for (int i = 0; i < 20; i++) begin
            send_sample(pick_component(), pick_component(), i == 19);
        end
        wait_results_drained();
        // step of 1 with the largest count: results flow, then an early end
        write_reg(CFG_IDX_STEP, 13'd1);
        write_reg(CFG_IDX_COUNT, 13'd4096);
        for (int i = 0; i < 30; i++) begin
            send_sample(pick_component(), pick_component(), i == 29);
        end
        wait_results_drained();

        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
